// File: rtl/core/crc32dp_pkg.sv
// ----------------------------------------------------------------------------
// crc32dp_pkg
// Shared types and constants for the CRC-32 direct preload engine.
// ----------------------------------------------------------------------------
package crc32dp_pkg;

  localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
  localparam logic [2:0]  PRELOAD_N  = 3'd4;   // bytes shifted in before inversion

  // running message state
  typedef struct packed {
    logic [31:0] remainder;
    logic [2:0]  bytes_seen;   // saturates at PRELOAD_N
    logic [31:0] seed_latch;
  } crc_state_t;

  // one finished message
  typedef struct packed {
    logic        vld;
    logic [31:0] crc_value;
    logic        short_message;
  } crc_result_t;

  // top byte pushed through eight polynomial steps
  function automatic logic [31:0] crc_table_entry(input logic [7:0] idx);
    logic [31:0] r;
    r = {idx, 24'd0};
    for (int k = 0; k < 8; k++) begin
      if (r[31]) begin
        r = {r[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[30:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/core/crc32dp_step.sv
// ----------------------------------------------------------------------------
// crc32dp_step
// Next-state and result logic for one message byte.
// ----------------------------------------------------------------------------
module crc32dp_step
  import crc32dp_pkg::*;
(
  input  crc_state_t  cur,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [31:0] seed,
  output crc_state_t  nxt,
  output crc_result_t res
);

  logic [31:0] shifted;
  logic [31:0] rem_new;
  logic [2:0]  cnt_new;
  logic [31:0] seed_eff;
  logic        is_short;

  always_comb begin
    shifted  = {cur.remainder[23:0], data_byte};
    seed_eff = (cur.bytes_seen == 3'd0) ? seed : cur.seed_latch;

    if (cur.bytes_seen < PRELOAD_N) begin
      cnt_new = cur.bytes_seen + 3'd1;
      rem_new = (cnt_new == PRELOAD_N) ? ~shifted : shifted;
    end else begin
      cnt_new = cur.bytes_seen;
      rem_new = shifted ^ crc_table_entry(cur.remainder[31:24]);
    end

    is_short = (cnt_new < PRELOAD_N);

    res.vld           = last_byte;
    res.crc_value     = is_short ? seed_eff : ~rem_new;
    res.short_message = is_short;

    // end of message returns the state to zero
    if (last_byte) begin
      nxt = '0;
    end else begin
      nxt.remainder  = rem_new;
      nxt.bytes_seen = cnt_new;
      nxt.seed_latch = seed_eff;
    end
  end

endmodule

// File: rtl/core/crc32_direct_preload_engine.sv
// ----------------------------------------------------------------------------
// crc32_direct_preload_engine
// Byte-serial CRC-32 (poly 0x04C11DB7, MSB first, augmented direct form).
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries one message byte per transaction; in_tlast marks
//   the final byte. The seed rides with every byte but is sampled only on
//   the first byte of a message. One result transaction leaves per message,
//   after its last byte: out_tdata is the inverted remainder, or the seed
//   when the message had fewer than four bytes, in which case out_tuser = 1.
//   Flow: a byte is registered at the input, taken by one table step into
//   the running state, and its result (if any) goes to the result register
//   driving out_tvalid. Throughput: one byte per cycle, set by the single
//   table step between input and state register, while no last byte waits.
//   Back-pressure: when out_tready is low the result register holds; bytes
//   that produce no result keep flowing, and a last byte waits in the input
//   register until the result slot frees, dropping in_tready only then.
//   Reset (rst_n low, synchronous) empties both stages and clears the
//   remainder, byte count and seed latch, so the next byte starts a message.
// ----------------------------------------------------------------------------
module crc32_direct_preload_engine
  import crc32dp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] data_byte, [39:8] seed
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] crc_value
  output logic        out_tuser   // [0] short_message
);

  logic        s1_vld_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic [31:0] s1_seed_r;

  crc_state_t  state_r;
  crc_state_t  state_nxt;
  crc_result_t res;

  logic        out_vld_r;
  logic [31:0] out_crc_r;
  logic        out_short_r;

  logic        out_free;
  logic        s1_adv;
  logic        in_acc;

  assign out_free  = !out_vld_r || out_tready;
  assign s1_adv    = s1_vld_r && (!s1_last_r || out_free);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  crc32dp_step u_step (
    .cur       (state_r),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .seed      (s1_seed_r),
    .nxt       (state_nxt),
    .res       (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
    if (in_acc) begin
      s1_byte_r <= in_tdata[7:0];
      s1_last_r <= in_tlast;
      s1_seed_r <= in_tdata[39:8];
    end
  end

  // running message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv && res.vld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
    if (s1_adv && res.vld) begin
      out_crc_r   <= res.crc_value;
      out_short_r <= res.short_message;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_crc_r;
  assign out_tuser  = out_short_r;

endmodule
